// ----- hdl/brer_pkg.sv -----
// shared types and default sizes for the buffered report event ring
`default_nettype none
package brer_pkg;

	localparam int DEF_MAX_MEMBERS = 32;
	localparam int DEF_RING_SLOTS  = 16;

	// one ring slot record
	typedef struct packed {
		logic [63:0] entry;
		logic [7:0]  seq;
		logic        ovf;
	} slot_rec_t;

endpackage
`default_nettype wire

// ----- hdl/brer_slot_mem.sv -----
// ring slot memory: one write port, one registered read port
`default_nettype none
module brer_slot_mem #(
	parameter int RING_SLOTS = brer_pkg::DEF_RING_SLOTS,
	parameter int HW = $clog2(RING_SLOTS)
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [HW-1:0]            waddr,
	input  wire brer_pkg::slot_rec_t wdata,
	input  wire [HW-1:0]            raddr,
	output brer_pkg::slot_rec_t     rdata
);

	brer_pkg::slot_rec_t mem_q [RING_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/buffered_report_event_ring_unit.sv -----
// buffered report event ring: top level with control sequencer and reason memory
// usage
//   input channel (in_valid / in_stall) carries one operation per transfer:
//   notify, capture if due, commit, replay from, resume after, rewind, purge,
//   set enable. the output channel (out_valid / out_stall) carries result
//   transfers; a capture that fires gives one result per marked member, in
//   member order, with last set on the final one, every other operation one.
// sequencing
//   one item at a time. rewind, purge, set enable and refused items pass through
//   accept, front slot read and result load; notify and commit first pass an
//   update or check state. replay and resume search the retained slots, with a
//   read and a check state per slot. a capture reads and emits per marked member.
//   the slot memory read is registered, which sets these steps.
// stalls
//   results sit in an output register; the next item is accepted while a
//   result still waits there, and the sequencer holds when it needs to load
//   a new result while out_stall keeps the old one.
// reset
//   arst_n clears all control state at once: ring empty, nothing pending,
//   block disabled, next entry number one. reason entries carry valid bits
//   so no clearing pass is needed; slot contents are only read once written.
// configuration
//   apb registers: 0x0 trigger_enables, 0x4 buffer_time, 0x8 member_count.
`default_nettype none
module buffered_report_event_ring_unit #(
	parameter int MAX_MEMBERS = brer_pkg::DEF_MAX_MEMBERS,
	parameter int RING_SLOTS  = brer_pkg::DEF_RING_SLOTS
) (
	input  wire         clk,
	input  wire         arst_n,
	// apb configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  operation,
	input  wire  [4:0]  member_id,
	input  wire  [1:0]  event_reason,
	input  wire  [63:0] now_ms,
	input  wire  [63:0] entry_key,
	input  wire         enable_value,
	// output channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  status,
	output logic        last,
	output logic [4:0]  included_member,
	output logic [7:0]  member_reasons,
	output logic [63:0] entry_num,
	output logic [7:0]  sequence_res,
	output logic        overflow_flag,
	output logic        front_valid,
	output logic [5:0]  pending_members,
	output logic [31:0] dropped_count,
	output logic        gap_flag,
	output logic [4:0]  retained_count
);

	localparam int MW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
	localparam int PW = $clog2(MAX_MEMBERS + 1);
	localparam int HW = $clog2(RING_SLOTS);
	localparam int CW = $clog2(RING_SLOTS + 1);

	// operation codes
	localparam logic [2:0] OP_NOTIFY  = 3'd0;
	localparam logic [2:0] OP_CAPTURE = 3'd1;
	localparam logic [2:0] OP_COMMIT  = 3'd2;
	localparam logic [2:0] OP_REPLAY  = 3'd3;
	localparam logic [2:0] OP_RESUME  = 3'd4;
	localparam logic [2:0] OP_REWIND  = 3'd5;
	localparam logic [2:0] OP_PURGE   = 3'd6;
	localparam logic [2:0] OP_SET_EN  = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DISABLED  = 3'd1;
	localparam logic [2:0] ST_NO_TRIG   = 3'd2;
	localparam logic [2:0] ST_RANGE     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_NOT_DUE   = 3'd5;

	// register indexes
	localparam logic [1:0] REG_TRIG  = 2'd0;
	localparam logic [1:0] REG_BTIME = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_NOTIFY_UPD, S_CAP_RD, S_CAP_EMIT, S_COMMIT_CHK,
		S_SEARCH_RD, S_SEARCH_CHK, S_FRONT_RD, S_FRONT_EMIT
	} state_t;

	// configuration registers
	logic [2:0]  trig_q;
	logic [31:0] btime_q;
	logic [5:0]  count_q;

	// block state
	state_t              state_q;
	logic [MAX_MEMBERS-1:0] rvalid_q;
	logic [MAX_MEMBERS-1:0] scan_q;
	logic                pending_q;
	logic [PW-1:0]       ptot_q;
	logic [63:0]         due_q;
	logic                enabled_q;
	logic [HW-1:0]       head_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       cursor_q;
	logic [CW-1:0]       srch_q;
	logic [63:0]         next_entry_q;
	logic [7:0]          last_seq_q;
	logic [31:0]         lost_q;
	logic                gap_q;
	logic [2:0]          res_status_q;

	// latched item
	logic [2:0]    op_q;
	logic [MW-1:0] member_q;
	logic [2:0]    bit_q;
	logic [63:0]   now_q;
	logic [63:0]   key_q;

	// captured entry and current scan member
	brer_pkg::slot_rec_t cap_q;
	logic [MW-1:0]       idx_q;

	// reason memory
	logic [2:0]    rsn_mem_q [MAX_MEMBERS];
	logic [2:0]    rsn_rdata;
	logic [MW-1:0] rsn_raddr;
	logic          rsn_we;
	logic [2:0]    rsn_wdata;

	// slot memory port
	logic                slot_we;
	logic [HW-1:0]       slot_waddr;
	brer_pkg::slot_rec_t slot_wdata;
	logic [HW-1:0]       slot_raddr;
	brer_pkg::slot_rec_t slot_rdata;

	function automatic logic [HW-1:0] phys(input logic [HW-1:0] head,
		input logic [CW-1:0] logical);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(logical);
		if (s >= (CW+1)'(RING_SLOTS)) begin
			s = s - (CW+1)'(RING_SLOTS);
		end
		return s[HW-1:0];
	endfunction

	// lowest set bit
	function automatic logic [MW-1:0] first_set(input logic [MAX_MEMBERS-1:0] v);
		logic [MW-1:0] r;
		logic          found;
		r = '0;
		found = 1'b0;
		for (int i = 0; i < MAX_MEMBERS; i++) begin
			if (v[i] && !found) begin
				r = MW'(i);
				found = 1'b1;
			end
		end
		return r;
	endfunction

	// apb
	wire       cfg_wr = psel && penable && pwrite;
	wire [1:0] cfg_idx = paddr[3:2];
	assign pready = 1'b1;

	always_comb begin
		case (cfg_idx)
			REG_TRIG:  prdata = {29'd0, trig_q};
			REG_BTIME: prdata = btime_q;
			REG_COUNT: prdata = {26'd0, count_q};
			default:   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q  <= 3'd7;
			btime_q <= 32'd0;
			count_q <= 6'd1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TRIG:  trig_q  <= pwdata[2:0];
				REG_BTIME: btime_q <= pwdata;
				REG_COUNT: count_q <= pwdata[5:0];
				default:   ;
			endcase
		end
	end

	// item decode in idle
	wire        accept   = in_valid && !in_stall;
	wire [2:0]  in_bit   = 3'(3'd4 >> event_reason);
	wire [6:0]  limit    = (7'(count_q) > 7'(MAX_MEMBERS)) ? 7'(MAX_MEMBERS) : 7'(count_q);
	wire        out_free = !out_valid || !out_stall;
	// a result is loaded into the output register this cycle
	wire        res_load = ((state_q == S_CAP_EMIT) || (state_q == S_FRONT_EMIT)) && out_free;
	wire        ring_full = (fill_q == CW'(RING_SLOTS));
	wire        cap_ovf   = ring_full && (cursor_q == '0);
	wire        cap_due   = pending_q && (ptot_q != '0) && (now_ms >= due_q);
	wire [64:0] due_sum   = {1'b0, now_q} + 65'(btime_q);
	wire [2:0]  rsn_old   = rvalid_q[member_q] ? rsn_rdata : 3'd0;
	wire        fv_now    = cursor_q < fill_q;
	wire [MW-1:0] in_member = MW'(7'(member_id));

	assign in_stall = (state_q != S_IDLE);

	// memory port control
	always_comb begin
		// while a capture result waits, keep reading the member being emitted
		if (state_q == S_IDLE) begin
			rsn_raddr = in_member;
		end else if (state_q == S_CAP_EMIT) begin
			rsn_raddr = idx_q;
		end else begin
			rsn_raddr = first_set(scan_q);
		end
		rsn_we     = (state_q == S_NOTIFY_UPD);
		rsn_wdata  = rsn_old | bit_q;
		slot_we    = (state_q == S_IDLE) && accept && (operation == OP_CAPTURE)
		             && enabled_q && cap_due;
		slot_waddr = ring_full ? head_q : phys(head_q, fill_q);
		slot_wdata.entry = next_entry_q;
		slot_wdata.seq   = last_seq_q + 8'd1;
		slot_wdata.ovf   = cap_ovf;
		case (state_q)
			S_SEARCH_RD: slot_raddr = phys(head_q, srch_q);
			default:     slot_raddr = phys(head_q, cursor_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (rsn_we) begin
			rsn_mem_q[member_q] <= rsn_wdata;
		end
		rsn_rdata <= rsn_mem_q[rsn_raddr];
	end

	brer_slot_mem #(
		.RING_SLOTS(RING_SLOTS),
		.HW(HW)
	) u_slot_mem (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	// sequencer, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			rvalid_q        <= '0;
			scan_q          <= '0;
			pending_q       <= 1'b0;
			ptot_q          <= '0;
			due_q           <= 64'd0;
			enabled_q       <= 1'b0;
			head_q          <= '0;
			fill_q          <= '0;
			cursor_q        <= '0;
			srch_q          <= '0;
			next_entry_q    <= 64'd1;
			last_seq_q      <= 8'd0;
			lost_q          <= 32'd0;
			gap_q           <= 1'b0;
			res_status_q    <= ST_OK;
			op_q            <= OP_NOTIFY;
			member_q        <= '0;
			bit_q           <= 3'd0;
			now_q           <= 64'd0;
			key_q           <= 64'd0;
			cap_q           <= '0;
			idx_q           <= '0;
			out_valid       <= 1'b0;
			status          <= ST_OK;
			last            <= 1'b0;
			included_member <= 5'd0;
			member_reasons  <= 8'd0;
			entry_num       <= 64'd0;
			sequence_res    <= 8'd0;
			overflow_flag   <= 1'b0;
			front_valid     <= 1'b0;
			pending_members <= 6'd0;
			dropped_count   <= 32'd0;
			gap_flag        <= 1'b0;
			retained_count  <= 5'd0;
		end else begin
			if (res_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= operation;
						member_q <= in_member;
						bit_q    <= in_bit;
						now_q    <= now_ms;
						key_q    <= entry_key;
						srch_q   <= '0;
						state_q  <= S_FRONT_RD;
						case (operation)
							OP_NOTIFY: begin
								if (!enabled_q) begin
									res_status_q <= ST_DISABLED;
								end else if (event_reason == 2'd3 || (trig_q & in_bit) == 3'd0) begin
									res_status_q <= ST_NO_TRIG;
								end else if (7'(member_id) >= limit) begin
									res_status_q <= ST_RANGE;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_NOTIFY_UPD;
								end
							end
							OP_CAPTURE: begin
								if (!enabled_q) begin
									res_status_q <= ST_DISABLED;
								end else if (!cap_due) begin
									res_status_q <= ST_NOT_DUE;
								end else begin
									// append the entry, then walk the snapshot of marked members
									cap_q <= slot_wdata;
									if (ring_full) begin
										if (cursor_q == '0) begin
											if (lost_q != 32'hFFFF_FFFF) begin
												lost_q <= lost_q + 32'd1;
											end
											gap_q <= 1'b1;
										end else begin
											cursor_q <= cursor_q - CW'(1);
										end
										head_q <= (head_q == HW'(RING_SLOTS - 1)) ? '0 : head_q + HW'(1);
									end else begin
										fill_q <= fill_q + CW'(1);
									end
									last_seq_q   <= slot_wdata.seq;
									next_entry_q <= (next_entry_q == 64'hFFFF_FFFF_FFFF_FFFF) ?
									                64'd1 : next_entry_q + 64'd1;
									scan_q    <= rvalid_q;
									rvalid_q  <= '0;
									pending_q <= 1'b0;
									ptot_q    <= '0;
									due_q     <= 64'd0;
									state_q   <= S_CAP_RD;
								end
							end
							OP_COMMIT: begin
								if (!fv_now) begin
									res_status_q <= ST_NOT_FOUND;
								end else begin
									state_q <= S_COMMIT_CHK;
								end
							end
							OP_REPLAY, OP_RESUME: begin
								if (fill_q == '0) begin
									res_status_q <= ST_NOT_FOUND;
								end else begin
									state_q <= S_SEARCH_RD;
								end
							end
							OP_REWIND: begin
								res_status_q <= ST_OK;
								cursor_q     <= '0;
							end
							OP_PURGE: begin
								res_status_q <= ST_OK;
								head_q       <= '0;
								fill_q       <= '0;
								cursor_q     <= '0;
								gap_q        <= 1'b0;
							end
							default: begin
								res_status_q <= ST_OK;
								if (enabled_q != enable_value) begin
									enabled_q <= enable_value;
									rvalid_q  <= '0;
									pending_q <= 1'b0;
									ptot_q    <= '0;
									due_q     <= 64'd0;
								end
							end
						endcase
					end
				end
				S_NOTIFY_UPD: begin
					// read-modify-write of the member's reason bits
					if (!pending_q) begin
						pending_q <= 1'b1;
						due_q     <= due_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : due_sum[63:0];
					end
					if (rsn_old == 3'd0) begin
						ptot_q <= ptot_q + PW'(1);
					end
					rvalid_q[member_q] <= 1'b1;
					state_q <= S_FRONT_RD;
				end
				S_CAP_RD: begin
					idx_q <= first_set(scan_q);
					scan_q[first_set(scan_q)] <= 1'b0;
					state_q <= S_CAP_EMIT;
				end
				S_CAP_EMIT: begin
					if (out_free) begin
						status          <= ST_OK;
						last            <= (scan_q == '0);
						included_member <= 5'(idx_q);
						member_reasons  <= {rsn_rdata, 5'd0};
						entry_num       <= cap_q.entry;
						sequence_res    <= cap_q.seq;
						overflow_flag   <= cap_q.ovf;
						front_valid     <= fv_now;
						pending_members <= 6'(ptot_q);
						dropped_count   <= lost_q;
						gap_flag        <= gap_q;
						retained_count  <= 5'(fill_q);
						state_q         <= (scan_q == '0) ? S_IDLE : S_CAP_RD;
					end
				end
				S_COMMIT_CHK: begin
					if (slot_rdata.entry == key_q) begin
						cursor_q     <= cursor_q + CW'(1);
						res_status_q <= ST_OK;
					end else begin
						res_status_q <= ST_NOT_FOUND;
					end
					state_q <= S_FRONT_RD;
				end
				S_SEARCH_RD: begin
					state_q <= S_SEARCH_CHK;
				end
				S_SEARCH_CHK: begin
					// oldest retained match wins
					if (slot_rdata.entry == key_q) begin
						cursor_q     <= (op_q == OP_REPLAY) ? srch_q : srch_q + CW'(1);
						res_status_q <= ST_OK;
						state_q      <= S_FRONT_RD;
					end else if (srch_q + CW'(1) == fill_q) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_FRONT_RD;
					end else begin
						srch_q  <= srch_q + CW'(1);
						state_q <= S_SEARCH_RD;
					end
				end
				S_FRONT_RD: begin
					state_q <= S_FRONT_EMIT;
				end
				S_FRONT_EMIT: begin
					if (out_free) begin
						status          <= res_status_q;
						last            <= 1'b1;
						included_member <= 5'd0;
						member_reasons  <= 8'd0;
						entry_num       <= fv_now ? slot_rdata.entry : 64'd0;
						sequence_res    <= fv_now ? slot_rdata.seq : 8'd0;
						overflow_flag   <= fv_now ? slot_rdata.ovf : 1'b0;
						front_valid     <= fv_now;
						pending_members <= 6'(ptot_q);
						dropped_count   <= lost_q;
						gap_flag        <= gap_q;
						retained_count  <= 5'(fill_q);
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// ring never holds more than its slots
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(RING_SLOTS))
		else $error("ring fill above slot count");

	// delivery cursor stays within the retained entries
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= fill_q)
		else $error("delivery cursor past fill");

	// pending member count tracks the marked reason entries
	a_pending_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ptot_q) == 32'($countones(rvalid_q)))
		else $error("pending count mismatch");

	// only capture results are followed by more results
	a_not_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (status == ST_OK && state_q != S_IDLE))
		else $error("non-final result outside a capture");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_buffered_report_event_ring_unit.sv -----
// testbench for the buffered report event ring: random and directed operations against a predictor
`timescale 1ns / 100ps
module tb_buffered_report_event_ring_unit;

	typedef enum logic [2:0] {
		OP_NOTIFY, OP_CAPTURE, OP_COMMIT, OP_REPLAY, OP_RESUME, OP_REWIND, OP_PURGE, OP_SET_ENABLE
	} op_e;

	typedef enum logic [2:0] {
		ST_OK, ST_DISABLED, ST_NO_TRIGGER, ST_RANGE, ST_NOT_FOUND, ST_NOT_DUE
	} status_e;

	localparam logic [3:0] REG_TRIGGERS = 4'h0;
	localparam logic [3:0] REG_BUF_TIME = 4'h4;
	localparam logic [3:0] REG_MEMBERS  = 4'h8;
	localparam int MEMBERS = brer_pkg::DEF_MAX_MEMBERS;
	localparam int SLOTS   = brer_pkg::DEF_RING_SLOTS;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [2:0]  status;
		logic        last;
		logic [4:0]  member;
		logic [7:0]  reasons;
		logic [63:0] entry;
		logic [7:0]  seq;
		logic        ovf;
		logic        fv;
		logic [5:0]  pend;
		logic [31:0] dropped;
		logic        gap;
		logic [4:0]  retained;
	} report_t;

	// predictor of the ring plus the queue of reports still owed by the block
	class ring_scoreboard;
		logic [2:0]  trig = 3'd7;
		logic [31:0] buf_time = 0;
		logic [5:0]  mcount = 1;
		logic [2:0]  rsn_bits [MEMBERS];
		bit          pend_flag;
		int          pend_total;
		logic [63:0] due;
		bit          en;
		int          head, fill, cursor;
		logic [63:0] next_entry = 1;
		logic [7:0]  last_seq = 8'd0;
		logic [31:0] lost = 32'd0;
		bit          gap;
		logic [63:0] slot_entry [SLOTS];
		logic [7:0]  slot_seq [SLOTS];
		bit          slot_ovf [SLOTS];
		report_t     owed [$];
		int          errors;

		function void drop_pending();
			foreach (rsn_bits[i]) rsn_bits[i] = 0;
			pend_flag = 0;
			pend_total = 0;
			due = 0;
		endfunction

		function int phys(int logical);
			return (head + logical) % SLOTS;
		endfunction

		function report_t state_row(status_e st, bit lst);
			report_t r;
			bit f;
			int p;
			f = cursor < fill;
			p = phys(cursor);
			r = '0;
			r.status = st;
			r.last = lst;
			r.entry = f ? slot_entry[p] : 64'd0;
			r.seq = f ? slot_seq[p] : 8'd0;
			r.ovf = f ? slot_ovf[p] : 1'b0;
			r.fv = f;
			r.pend = pend_total[5:0];
			r.dropped = lost;
			r.gap = gap;
			r.retained = fill[4:0];
			return r;
		endfunction

		// an entry number that the ring holds, or now and then any number
		function logic [63:0] pick_key();
			if (fill == 0 || $urandom_range(0, 9) == 0)
				return {$urandom, $urandom};
			return slot_entry[phys($urandom_range(0, fill - 1))];
		endfunction

		function void note_item(op_e op, logic [4:0] mi, logic [1:0] rs, logic [63:0] now,
				logic [63:0] key, bit ev);
			logic [2:0] bit_sel;
			int lim, n, target, where;
			bit full, ovf;
			int mem_list [$];
			logic [2:0] mask_list [$];
			report_t r;
			case (op)
				OP_NOTIFY: begin
					bit_sel = 3'd4 >> rs;
					lim = (mcount > MEMBERS) ? MEMBERS : mcount;
					if (!en) owed.push_back(state_row(ST_DISABLED, 1));
					else if (rs == 2'd3 || (trig & bit_sel) == 0)
						owed.push_back(state_row(ST_NO_TRIGGER, 1));
					else if (mi >= lim) owed.push_back(state_row(ST_RANGE, 1));
					else begin
						if (!pend_flag) begin
							pend_flag = 1;
							due = (buf_time > ~now) ? '1 : now + buf_time;
						end
						if (rsn_bits[mi] == 0) pend_total++;
						rsn_bits[mi] |= bit_sel;
						owed.push_back(state_row(ST_OK, 1));
					end
				end
				OP_CAPTURE: begin
					foreach (rsn_bits[i])
						if (rsn_bits[i] != 0) begin
							mem_list.push_back(i);
							mask_list.push_back(rsn_bits[i]);
						end
					n = mem_list.size();
					if (!en) owed.push_back(state_row(ST_DISABLED, 1));
					else if (!pend_flag || pend_total == 0 || now < due || n == 0)
						owed.push_back(state_row(ST_NOT_DUE, 1));
					else begin
						full = fill >= SLOTS;
						ovf = full && cursor == 0;
						target = full ? head : phys(fill);
						slot_entry[target] = next_entry;
						slot_seq[target] = last_seq + 8'd1;
						slot_ovf[target] = ovf;
						if (full) begin
							if (cursor == 0) begin
								if (lost != '1) lost++;
								gap = 1;
							end else cursor--;
							head = (head + 1) % SLOTS;
						end else fill++;
						last_seq = last_seq + 8'd1;
						drop_pending();
						for (int i = 0; i < n; i++) begin
							r = state_row(ST_OK, i == n - 1);
							r.member = 5'(mem_list[i]);
							r.reasons = {mask_list[i], 5'd0};
							r.entry = next_entry;
							r.seq = last_seq;
							r.ovf = ovf;
							owed.push_back(r);
						end
						next_entry = (next_entry == '1) ? 64'd1 : next_entry + 64'd1;
					end
				end
				OP_COMMIT: begin
					if (cursor >= fill || slot_entry[phys(cursor)] != key)
						owed.push_back(state_row(ST_NOT_FOUND, 1));
					else begin
						cursor++;
						owed.push_back(state_row(ST_OK, 1));
					end
				end
				OP_REPLAY, OP_RESUME: begin
					where = -1;
					for (int i = 0; i < fill; i++)
						if (where < 0 && slot_entry[phys(i)] == key) where = i;
					if (where < 0) owed.push_back(state_row(ST_NOT_FOUND, 1));
					else begin
						cursor = (op == OP_REPLAY) ? where : where + 1;
						owed.push_back(state_row(ST_OK, 1));
					end
				end
				OP_REWIND: begin
					cursor = 0;
					owed.push_back(state_row(ST_OK, 1));
				end
				OP_PURGE: begin
					head = 0;
					fill = 0;
					cursor = 0;
					gap = 0;
					owed.push_back(state_row(ST_OK, 1));
				end
				default: begin
					if (en != ev) begin
						en = ev;
						drop_pending();
					end
					owed.push_back(state_row(ST_OK, 1));
				end
			endcase
		endfunction

		function void field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_report(report_t got);
			report_t w;
			if (owed.size() == 0) begin
				$display("%0t: unexpected report, expected none got %p", $time, got);
				errors++;
				return;
			end
			w = owed.pop_front();
			field("status", w.status, got.status);
			field("last", w.last, got.last);
			field("included_member", w.member, got.member);
			field("member_reasons", w.reasons, got.reasons);
			field("entry_num", w.entry, got.entry);
			field("sequence_res", w.seq, got.seq);
			field("overflow_flag", w.ovf, got.ovf);
			field("front_valid", w.fv, got.fv);
			field("pending_members", w.pend, got.pend);
			field("dropped_count", w.dropped, got.dropped);
			field("gap_flag", w.gap, got.gap);
			field("retained_count", w.retained, got.retained);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] operation = 0;
	logic [4:0] member_id = 0;
	logic [1:0] event_reason = 0;
	logic [63:0] now_ms = 0;
	logic [63:0] entry_key = 0;
	logic enable_value = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic last;
	logic [4:0] included_member;
	logic [7:0] member_reasons;
	logic [63:0] entry_num;
	logic [7:0] sequence_res;
	logic overflow_flag, front_valid;
	logic [5:0] pending_members;
	logic [31:0] dropped_count;
	logic gap_flag;
	logic [4:0] retained_count;

	ring_scoreboard sb = new();
	logic [63:0] clock_ms = 64'd1000;
	bit busy_sides = 1;     // when clear neither side idles
	bit long_hold;          // asks the receiver for one long hold-off
	int cycles;

	buffered_report_event_ring_unit dut (.*);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// every accepted result transfer is checked against the oldest owed report
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_report({status, last, included_member, member_reasons, entry_num,
				sequence_res, overflow_flag, front_valid, pending_members, dropped_count,
				gap_flag, retained_count});
	end

	// receiver: stall for a drawn number of cycles, then take one transfer
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				k = 400;
				long_hold = 0;
			end else k = busy_sides ? $urandom_range(0, 9) : 0;
			if (k > 0) begin
				out_stall <= 1;
				repeat (k) @(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// apb write: setup cycle, access cycle, then idle
	task automatic reg_write(logic [3:0] addr, logic [31:0] value);
		psel <= 1;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (addr)
			REG_TRIGGERS: sb.trig = value[2:0];
			REG_BUF_TIME: sb.buf_time = value;
			default:      sb.mcount = value[5:0];
		endcase
		@(negedge clk);
	endtask

	task automatic set_registers(logic [2:0] trig, logic [31:0] bt, logic [5:0] mc);
		reg_write(REG_TRIGGERS, {29'd0, trig});
		reg_write(REG_BUF_TIME, bt);
		reg_write(REG_MEMBERS, {26'd0, mc});
	endtask

	// one input transfer; entered and left at a falling edge
	task automatic send_op(op_e op, logic [4:0] mi, logic [1:0] rs, logic [63:0] now,
			logic [63:0] key, bit ev);
		int g;
		g = busy_sides ? $urandom_range(0, 9) : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		operation <= op;
		member_id <= mi;
		event_reason <= rs;
		now_ms <= now;
		entry_key <= key;
		enable_value <= ev;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_item(op, mi, rs, now, key, ev);
		@(negedge clk);
	endtask

	// wait until every owed report came back, plus room for the slowest item
	task automatic drain();
		in_valid <= 0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic random_op();
		int pick;
		logic [63:0] now;
		clock_ms += $urandom_range(0, 40);
		now = clock_ms;
		pick = $urandom_range(0, 99);
		if (pick < 4) now = {$urandom, $urandom};
		else if (pick < 7) now = '1;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			send_op(OP_NOTIFY, 5'($urandom_range(0, 31)),
				($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
				now, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
		else if (pick < 68)
			send_op(OP_CAPTURE, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)), now,
				{$urandom, $urandom}, 1'($urandom_range(0, 1)));
		else if (pick < 80)
			send_op(OP_COMMIT, 0, 0, now,
				(sb.cursor < sb.fill && $urandom_range(0, 3) != 0) ?
				sb.slot_entry[sb.phys(sb.cursor)] : sb.pick_key(), 0);
		else if (pick < 88)
			send_op(op_e'($urandom_range(OP_REPLAY, OP_RESUME)), 0, 0, now, sb.pick_key(), 0);
		else if (pick < 92) send_op(OP_REWIND, 0, 0, now, 0, 0);
		else if (pick < 94) send_op(OP_PURGE, 0, 0, now, 0, 0);
		else
			// mostly keep the block enabled so events get through
			send_op(OP_SET_ENABLE, 0, 0, now, 0, $urandom_range(0, 7) != 0);
	endtask

	initial begin
		sb.drop_pending();
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: refusals while disabled, every reason, range limit, ring operations
		send_op(OP_NOTIFY, 0, 0, 100, 0, 0);
		send_op(OP_CAPTURE, 0, 0, 100, 0, 0);
		send_op(OP_SET_ENABLE, 0, 0, 0, 0, 1);
		send_op(OP_SET_ENABLE, 0, 0, 0, 0, 1);
		send_op(OP_CAPTURE, 0, 0, 100, 0, 0);
		send_op(OP_NOTIFY, 0, 2'd3, 100, 0, 0);
		send_op(OP_NOTIFY, 5, 0, 100, 0, 0);
		send_op(OP_NOTIFY, 0, 0, 100, 0, 0);
		send_op(OP_NOTIFY, 0, 1, 101, 0, 0);
		send_op(OP_NOTIFY, 0, 2, 102, 0, 0);
		send_op(OP_CAPTURE, 0, 0, 100, 0, 0);
		send_op(OP_COMMIT, 0, 0, 0, 64'd7, 0);
		send_op(OP_COMMIT, 0, 0, 0, 64'd1, 0);
		send_op(OP_REPLAY, 0, 0, 0, 64'd1, 0);
		send_op(OP_RESUME, 0, 0, 0, 64'd1, 0);
		send_op(OP_REPLAY, 0, 0, 0, '1, 0);
		send_op(OP_REWIND, 0, 0, 0, 0, 0);
		send_op(OP_NOTIFY, 0, 1, 200, 0, 0);
		send_op(OP_SET_ENABLE, 0, 0, 0, 0, 0);
		send_op(OP_SET_ENABLE, 0, 0, 0, 0, 1);
		send_op(OP_PURGE, 0, 0, 0, 0, 0);
		drain();

		// phases over register settings, extremes included; pending marks carry across
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_registers(3'd7, 32'd0, 6'd32);
				1: set_registers(3'd5, 32'd25, 6'd32);
				2: set_registers(3'd0, 32'd3, 6'd8);
				3: set_registers(3'd7, 32'hFFFF_FFFF, 6'd0);
				4: set_registers(3'd3, 32'd10, 6'd63);
				5: set_registers(3'd6, 32'd1, 6'd4);
				default: set_registers(3'd7, 32'd0, 6'd20);
			endcase
			busy_sides = (ph % 3) != 2;
			if (ph == 1) long_hold = 1;
			if (ph == 2) begin
				send_op(OP_NOTIFY, 31, 0, clock_ms, '1, 1);
				send_op(OP_NOTIFY, 0, 0, clock_ms, '1, 1);
			end
			for (int i = 0; i < 62; i++) random_op();
			drain();
		end
		busy_sides = 1;

		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- buffered_report_event_ring_unit.f -----
hdl/brer_pkg.sv
hdl/brer_slot_mem.sv
hdl/buffered_report_event_ring_unit.sv
sim/tb_buffered_report_event_ring_unit.sv
